[hw/rtl/dstq_pkg.sv]
package dstq_pkg;

    localparam int SLOTS_DEF = 16;

    typedef enum logic [2:0] {
        K_FIRED   = 3'd0,
        K_DELAY   = 3'd1,
        K_STOPPED = 3'd2,
        K_FULL    = 3'd3,
        K_IDLE    = 3'd4
    } t_kind;

    localparam logic OP_SCHED = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [63:0]        now_time;
        logic [63:0]        deadline;
        logic [7:0]         work_id;
        logic signed [31:0] work_arg;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         fired_id;
        logic signed [31:0] fired_arg;
        logic [63:0]        fire_time;
        logic [63:0]        delay;
        logic               last;
    } t_out_word;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input word
        logic rd_head;   // read entry at head
        logic rd_walk;   // read next of walk cursor
        logic step_walk; // cursor <= read index
        logic ins_head;  // link new entry as head
        logic ins_after; // link new entry after cursor
        logic pop_head;  // drop head
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic full;
        logic due_now;   // input deadline <= now
        logic empty;
        logic rd_nil;    // read link is nil
        logic rd_le;     // read deadline <= input deadline
        logic rd_due;    // read deadline <= now
    } t_sts;

endpackage

[hw/rtl/dstq_ram.sv]
module dstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[hw/rtl/dstq_dp.sv]
module dstq_dp
    import dstq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_in_word  o_cur,
    output logic [63:0] o_rd_dl,
    output logic [7:0]  o_rd_id,
    output logic [31:0] o_rd_arg
);
    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1; // link with nil bit

    t_in_word        r_cur;
    logic [SLOTS-1:0] r_valid;
    logic [LW-1:0]   r_head;
    logic [IW-1:0]   r_walk;   // walk cursor
    logic [IW-1:0]   r_free;   // slot of new entry
    logic [IW-1:0]   r_ridx;   // index of last read
    logic [IW-1:0]   n_free;
    logic            n_full;
    logic [IW-1:0]   raddr;
    logic [LW-1:0]   rd_next;
    logic            we_data, we_link;
    logic [IW-1:0]   link_addr;
    logic [LW-1:0]   link_data;

    // lowest free slot
    always_comb begin
        n_full = 1'b1;
        n_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                n_full = 1'b0;
                n_free = IW'(i);
            end
        end
    end

    // read port address
    always_comb begin
        raddr = r_head[IW-1:0];
        if (i_cmd.rd_walk) raddr = rd_next[IW-1:0];
    end

    // link writes: head insert, after-cursor insert
    // after the cursor: successor is the last read entry, or nil at the tail
    always_comb begin
        we_data   = i_cmd.ins_head || i_cmd.ins_after;
        we_link   = we_data;
        link_addr = r_free;
        if (i_cmd.ins_head)
            link_data = r_head;
        else if (r_ridx == r_walk)
            link_data = rd_next;
        else
            link_data = {1'b0, r_ridx};
    end

    dstq_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_dl (
        .i_clk, .i_we(we_data), .i_waddr(r_free), .i_wdata(r_cur.deadline),
        .i_raddr(raddr), .o_rdata(o_rd_dl));
    dstq_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_id (
        .i_clk, .i_we(we_data), .i_waddr(r_free), .i_wdata(r_cur.work_id),
        .i_raddr(raddr), .o_rdata(o_rd_id));
    dstq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_arg (
        .i_clk, .i_we(we_data), .i_waddr(r_free), .i_wdata(r_cur.work_arg),
        .i_raddr(raddr), .o_rdata(o_rd_arg));

    // next links: small and written at two addresses, kept in flops
    logic [LW-1:0] r_next [SLOTS];
    always_ff @(posedge i_clk) begin
        if (we_link) r_next[link_addr] <= link_data;
        if (i_cmd.ins_after) r_next[r_walk] <= {1'b0, r_free};
    end
    assign rd_next = r_next[r_ridx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= LW'(SLOTS);
        end else begin
            if (we_data) r_valid[r_free] <= 1'b1;
            if (i_cmd.ins_head) r_head <= {1'b0, r_free};
            if (i_cmd.pop_head) begin
                r_valid[r_head[IW-1:0]] <= 1'b0;
                r_head <= r_next[r_head[IW-1:0]];
            end
        end
        if (i_cmd.load) begin
            r_cur  <= i_word;
            r_free <= n_free;
        end
        if (i_cmd.rd_head || i_cmd.rd_walk) r_ridx <= raddr;
        if (i_cmd.rd_head) r_walk <= r_head[IW-1:0];
        if (i_cmd.step_walk) r_walk <= r_ridx;
    end

    assign o_sts.full    = n_full;
    assign o_sts.due_now = r_cur.deadline <= r_cur.now_time;
    assign o_sts.empty   = r_head >= LW'(SLOTS);
    assign o_sts.rd_nil  = rd_next >= LW'(SLOTS);
    assign o_sts.rd_le   = o_rd_dl <= r_cur.deadline;
    assign o_sts.rd_due  = o_rd_dl <= r_cur.now_time;
    assign o_cur = r_cur;
endmodule

[hw/rtl/dstq_ctrl.sv]
module dstq_ctrl
    import dstq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_word,
    output t_cmd        o_cmd,
    input  t_sts        i_sts,
    input  t_in_word    i_cur,
    input  logic [63:0] i_rd_dl,
    input  logic [7:0]  i_rd_id,
    input  logic [31:0] i_rd_arg
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_HREAD, S_HCHK, S_WALK, S_WCHK, S_OUT, S_STOP
    } t_state;

    t_state    r_state, n_state;
    t_out_word r_word, n_word;
    logic      r_valid, n_valid;
    logic      r_tick, n_tick;    // item is a tick
    logic      r_fired, n_fired;  // tick fired at least one
    logic      r_ret, n_ret;      // back to HREAD after output

    // next-state and command logic
    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_valid = r_valid;
        n_tick  = r_tick;
        n_fired = r_fired;
        n_ret   = r_ret;
        o_cmd   = '0;
        if (r_valid && i_ready) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !r_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_word  = '0;
                n_word.last = 1'b1;
                n_tick  = i_cur.opcode == OP_TICK;
                n_fired = 1'b0;
                n_ret   = 1'b0;
                if (i_cur.opcode == OP_TICK) begin
                    if (i_sts.empty) begin
                        n_word.kind = K_IDLE;
                        n_state     = S_OUT;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_HREAD;
                    end
                end else if (i_sts.full) begin
                    n_word.kind = K_FULL;
                    n_state     = S_OUT;
                end else if (i_sts.due_now) begin
                    n_word.kind      = K_FIRED;
                    n_word.fired_id  = i_cur.work_id;
                    n_word.fired_arg = i_cur.work_arg;
                    n_word.fire_time = i_cur.now_time;
                    n_state          = S_OUT;
                end else if (i_sts.empty) begin
                    o_cmd.ins_head = 1'b1;
                    n_word.kind    = K_DELAY;
                    n_word.delay   = i_cur.deadline - i_cur.now_time;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_HREAD;
                end
            end
            S_HREAD: begin
                // registered read; also wait until the previous word is taken
                if (!r_valid || i_ready) n_state = S_HCHK;
            end
            S_HCHK: begin
                n_word = '0;
                if (r_tick) begin
                    if (i_sts.rd_due) begin
                        o_cmd.pop_head   = 1'b1;
                        n_word.kind      = K_FIRED;
                        n_word.fired_id  = i_rd_id;
                        n_word.fired_arg = i_rd_arg;
                        n_word.fire_time = i_cur.now_time;
                        n_fired          = 1'b1;
                        n_ret            = !i_sts.rd_nil;
                        n_state          = S_OUT;
                        if (i_sts.rd_nil) n_ret = 1'b0;
                    end else begin
                        n_word.last  = 1'b1;
                        n_word.kind  = r_fired ? K_DELAY : K_IDLE;
                        n_word.delay = r_fired ? i_rd_dl - i_cur.now_time : '0;
                        n_ret        = 1'b0;
                        n_state      = S_OUT;
                    end
                end else if (!i_sts.rd_le) begin
                    o_cmd.ins_head = 1'b1;
                    n_word.last    = 1'b1;
                    n_word.kind    = K_DELAY;
                    n_word.delay   = i_cur.deadline - i_cur.now_time;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                // cursor entry data valid; decide on its successor
                n_word = '0;
                if (i_sts.rd_nil) begin
                    o_cmd.ins_after = 1'b1;
                    n_word.last     = 1'b1;
                    n_word.kind     = K_IDLE;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state       = S_WALK;
                end
            end
            S_WALK: begin
                n_word = '0;
                if (i_sts.rd_le) begin
                    o_cmd.step_walk = 1'b1;
                    n_state         = S_WCHK;
                end else begin
                    // successor is later: link between cursor and successor
                    o_cmd.ins_after = 1'b1;
                    n_word.last     = 1'b1;
                    n_word.kind     = K_IDLE;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                // word is staged with no earlier word pending
                n_valid = 1'b1;
                if (r_ret) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_HREAD;
                end else if (!r_word.last) begin
                    n_state = S_STOP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_STOP: begin
                // list emptied after a firing; follow up once the firing is taken
                if (!r_valid || i_ready) begin
                    n_word      = '0;
                    n_word.kind = K_STOPPED;
                    n_word.last = 1'b1;
                    n_fired     = 1'b0;
                    n_state     = S_OUT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_tick  <= 1'b0;
            r_fired <= 1'b0;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_tick  <= n_tick;
            r_fired <= n_fired;
            r_ret   <= n_ret;
        end
        if (r_state != S_OUT || !r_valid || i_ready) r_word <= n_word;
    end

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

[hw/rtl/deadline_sorted_timer_queue.sv]
// Schedule walks the sorted list from the head, one entry at a time, to find the
// new entry's place; a tick fires due entries from the head, one word per entry.
// One item at a time: the next item is taken once the last result word has
// left, so the length of the list walk sets the pace.
// Reset: synchronous active low; empties the list, slot RAMs keep contents.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);
    t_cmd        cmd;
    t_sts        sts;
    t_in_word    cur;
    logic [63:0] rd_dl;
    logic [7:0]  rd_id;
    logic [31:0] rd_arg;

    dstq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_word,
        .o_cmd(cmd), .i_sts(sts), .i_cur(cur),
        .i_rd_dl(rd_dl), .i_rd_id(rd_id), .i_rd_arg(rd_arg));

    dstq_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_word, .i_cmd(cmd), .o_sts(sts), .o_cur(cur),
        .o_rd_dl(rd_dl), .o_rd_id(rd_id), .o_rd_arg(rd_arg));
endmodule

[hw/rtl/dstq_checker.sv]
module dstq_checker
    import dstq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_word
);
    // result word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("result word changed while stalled");
    // no new item accepted while a result is pending inside the block
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.last |-> !o_ready)
        else $error("accepted item mid-sequence");
    // fired id is zero on other kinds
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.kind != K_FIRED |-> o_word.fired_id == 8'd0)
        else $error("fired id set on non-fire word");
    // only fired words may be non-final
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.last |-> o_word.kind == K_FIRED)
        else $error("non-final word not a firing");
endmodule

bind deadline_sorted_timer_queue dstq_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_word);
